// ===== hdl/hpdc_pkg.sv =====
// Shared types and widths of the heading PD controller.
package hpdc_pkg;

    // Width of the shared add/subtract unit; covers the widest drive sum
    localparam int ALU_W = 36;

    // Register map of the configuration port
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [2:0] REG_MAX_DRIVE  = 3'd2;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd3;

    // Operation handed to the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    // Result of the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
    } t_alu_rsp;

endpackage

// ===== hdl/hpdc_alu.sv =====
// Shared add/subtract unit with sign flag for the heading PD controller.
module hpdc_alu
    import hpdc_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] w_b;
    logic [ALU_W-1:0] w_sum;

    // Invert and carry in for subtraction
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign w_sum = i_req.a + w_b + ALU_W'(i_req.sub);

    assign o_rsp.sum = w_sum;
    assign o_rsp.neg = w_sum[ALU_W-1];

endmodule

// ===== hdl/heading_pd_controller_unit.sv =====
// Heading PD controller: handshake, configuration, sequencer and datapath.
//
// Input channel: i_in_valid with the heading, target offset, elapsed time and
// re-zero flag; the block raises o_in_stall while it works on a word. Output
// channel: o_out_valid with drive, wrapped error and dead-band flag; the
// receiver holds a word with i_out_stall. Configuration: i_cfg_valid with
// i_cfg_index and i_cfg_data, always ready (o_cfg_ready); indexes 0 to 3 are
// prop_gain, deriv_gain, max_drive and dead_band, others are dropped.
// The sequencer works a word step by step on the one shared adder; the
// derivative term uses a 26-step restoring divider that runs on that adder.
// A word inside the dead band goes from the dead-band step straight to the
// last step, and a word with zero elapsed time skips the divider. The
// next word is accepted in the cycle after the result is loaded into the
// output register, also while that result still waits on a stalled
// receiver. A finished result whose output register is still held waits in
// the last step until it drains.
// Synchronous reset clears the configuration registers, the output valid,
// the reference heading and the previous error; the first word after reset
// sets the reference.
module heading_pd_controller_unit
    import hpdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_heading_now,
    input  logic signed [15:0] i_target_offset,
    input  logic [15:0]        i_elapsed_ms,
    input  logic               i_rezero,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_drive,
    output logic signed [15:0] o_wrapped_error,
    output logic               o_in_dead_band,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int FULL_TURN = 36000;
    localparam int MS_PER_S  = 1000;
    localparam int DIV_STEPS = 26;

    localparam logic signed [17:0] T_HALF  = 18'sd18000;
    localparam logic signed [17:0] T_NHALF = -18'sd18000;

    typedef enum logic [4:0] {
        S_IDLE, S_HEAD, S_OFS, S_W1, S_ERR, S_W2, S_DB, S_ABSD, S_MUL1K,
        S_DIV, S_ABSE, S_MULP, S_MULD, S_SUM1, S_SUM2, S_SAT1, S_SAT2,
        S_SAT3, S_FIN
    } t_state;

    // configuration registers
    logic [15:0] r_pg;
    logic [15:0] r_dg;
    logic [14:0] r_max;
    logic [14:0] r_db;

    // sequencer and datapath registers
    t_state             r_state;
    logic [15:0]        r_heading;
    logic [15:0]        r_target;
    logic [15:0]        r_elapsed;
    logic               r_rezero;
    logic [15:0]        r_head;
    logic [15:0]        r_ref;
    logic               r_ref_valid;
    logic [15:0]        r_prev;
    logic [17:0]        r_t;
    logic [15:0]        r_err;
    logic [16:0]        r_diff;
    logic               r_quiet;
    logic [15:0]        r_dmag;
    logic [15:0]        r_emag;
    logic [15:0]        r_rem;
    logic [25:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [23:0]        r_pm;
    logic [33:0]        r_dm;
    logic [ALU_W-1:0]   r_acc;
    logic               r_low_clamp;
    logic               r_out_valid;
    logic [15:0]        r_drive;
    logic [15:0]        r_werr;
    logic               r_dbflag;

    t_alu_req    w_req;
    t_alu_rsp    w_rsp;
    logic [25:0] w_ma;
    logic [15:0] w_mb;
    logic [41:0] w_prod;
    logic        w_fold_hi;
    logic        w_fold_lo;
    logic        w_use_new;
    logic [16:0] w_shift;
    logic signed [16:0] w_err_sx;
    logic signed [16:0] w_db_pos;
    logic signed [16:0] w_db_neg;
    logic        w_quiet;
    logic        w_in_acc;
    logic        w_load;

    hpdc_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Load the output register from the last step once it is free
    assign w_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // Shared multiplier, registered at every use
    assign w_prod = 42'(w_ma) * 42'(w_mb);

    // Single-fold window tests on the working angle
    assign w_fold_hi = $signed(r_t) > T_HALF;
    assign w_fold_lo = $signed(r_t) < T_NHALF;
    assign w_use_new = !r_ref_valid || r_rezero;
    assign w_shift   = {r_rem, r_quo[25]};

    // Dead-band window test on the stored error
    assign w_err_sx = $signed({r_err[15], r_err});
    assign w_db_pos = $signed({2'b00, r_db});
    assign w_db_neg = -w_db_pos;
    assign w_quiet  = (w_err_sx <= w_db_pos) && (w_err_sx >= w_db_neg);

    // Drive the shared adder and multiplier by step
    always_comb begin
        w_req = '0;
        w_ma  = '0;
        w_mb  = '0;
        unique case (r_state)
            S_HEAD: begin
                w_req.a   = ALU_W'(r_heading);
                w_req.b   = ALU_W'(FULL_TURN);
                w_req.sub = 1'b1;
            end
            S_OFS: begin
                w_req.a   = ALU_W'(r_head);
                w_req.b   = w_use_new ? ALU_W'(r_head) : ALU_W'(r_ref);
                w_req.sub = 1'b1;
            end
            S_W1, S_W2: begin
                w_req.a   = ALU_W'($signed(r_t));
                w_req.b   = (w_fold_hi || w_fold_lo) ? ALU_W'(FULL_TURN) : '0;
                w_req.sub = w_fold_hi;
            end
            S_ERR: begin
                w_req.a   = ALU_W'($signed(r_t));
                w_req.b   = ALU_W'($signed(r_target));
                w_req.sub = 1'b1;
            end
            S_DB: begin
                w_req.a   = ALU_W'($signed(r_err));
                w_req.b   = ALU_W'($signed(r_prev));
                w_req.sub = 1'b1;
            end
            S_ABSD: begin
                w_req.b   = ALU_W'($signed(r_diff));
                w_req.sub = r_diff[16];
            end
            S_MUL1K: begin
                w_ma = 26'(r_dmag);
                w_mb = 16'(MS_PER_S);
            end
            S_DIV: begin
                w_req.a   = ALU_W'(w_shift);
                w_req.b   = ALU_W'(r_elapsed);
                w_req.sub = 1'b1;
            end
            S_ABSE: begin
                w_req.b   = ALU_W'($signed(r_err));
                w_req.sub = r_err[15];
            end
            S_MULP: begin
                w_ma = 26'(r_emag);
                w_mb = r_pg;
            end
            S_MULD: begin
                w_ma = r_quo;
                w_mb = r_dg;
            end
            S_SUM1: begin
                w_req.b   = ALU_W'(r_pm);
                w_req.sub = !r_err[15];
            end
            S_SUM2: begin
                w_req.a   = r_acc;
                w_req.b   = ALU_W'(r_dm);
                w_req.sub = !r_diff[16];
            end
            S_SAT1: begin
                w_req.a   = r_acc;
                w_req.b   = ALU_W'(r_max);
                w_req.sub = 1'b1;
            end
            S_SAT2: begin
                w_req.a   = r_acc;
                w_req.b   = ALU_W'(r_max);
            end
            S_SAT3: begin
                w_req.b   = ALU_W'(r_max);
                w_req.sub = 1'b1;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg  <= '0;
            r_dg  <= '0;
            r_max <= '0;
            r_db  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:  r_pg  <= i_cfg_data;
                REG_DERIV_GAIN: r_dg  <= i_cfg_data;
                REG_MAX_DRIVE:  r_max <= i_cfg_data[14:0];
                REG_DEAD_BAND:  r_db  <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ref       <= '0;
            r_ref_valid <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished word, or drop the output word once taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_heading <= i_heading_now;
                        r_target  <= i_target_offset;
                        r_elapsed <= i_elapsed_ms;
                        r_rezero  <= i_rezero;
                        r_state   <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_head  <= w_rsp.neg ? r_heading : w_rsp.sum[15:0];
                    r_state <= S_OFS;
                end
                S_OFS: begin
                    r_t <= w_rsp.sum[17:0];
                    if (w_use_new) begin
                        r_ref       <= r_head;
                        r_ref_valid <= 1'b1;
                        r_prev      <= '0;
                    end
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_t     <= w_rsp.sum[17:0];
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_t     <= w_rsp.sum[17:0];
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_err   <= w_rsp.sum[15:0];
                    r_state <= S_DB;
                end
                S_DB: begin
                    r_quiet <= w_quiet;
                    r_diff  <= w_rsp.sum[16:0];
                    r_prev  <= r_err;
                    r_quo   <= '0;
                    if (w_quiet) begin
                        r_state <= S_FIN;
                    end else if (r_elapsed == '0) begin
                        r_state <= S_ABSE;
                    end else begin
                        r_state <= S_ABSD;
                    end
                end
                S_ABSD: begin
                    r_dmag  <= w_rsp.sum[15:0];
                    r_state <= S_MUL1K;
                end
                S_MUL1K: begin
                    r_quo   <= w_prod[25:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one restoring step: keep the trial remainder if it fits
                    if (w_rsp.neg) begin
                        r_rem <= w_shift[15:0];
                        r_quo <= {r_quo[24:0], 1'b0};
                    end else begin
                        r_rem <= w_rsp.sum[15:0];
                        r_quo <= {r_quo[24:0], 1'b1};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_ABSE;
                    end
                end
                S_ABSE: begin
                    r_emag  <= w_rsp.sum[15:0];
                    r_state <= S_MULP;
                end
                S_MULP: begin
                    r_pm    <= w_prod[31:8];
                    r_state <= S_MULD;
                end
                S_MULD: begin
                    r_dm    <= w_prod[41:8];
                    r_state <= S_SUM1;
                end
                S_SUM1: begin
                    r_acc   <= w_rsp.sum;
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_acc   <= w_rsp.sum;
                    r_state <= S_SAT1;
                end
                S_SAT1: begin
                    // clamp from above when the sum reaches the limit
                    if (!w_rsp.neg) begin
                        r_acc <= ALU_W'(r_max);
                    end
                    r_state <= S_SAT2;
                end
                S_SAT2: begin
                    r_low_clamp <= w_rsp.neg;
                    r_state     <= S_SAT3;
                end
                S_SAT3: begin
                    if (r_low_clamp) begin
                        r_acc <= w_rsp.sum;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (w_load) begin
                        r_drive  <= r_quiet ? '0 : r_acc[15:0];
                        r_werr   <= r_err;
                        r_dbflag <= r_quiet;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_wrapped_error = r_werr;
    assign o_in_dead_band  = r_dbflag;

`ifndef SYNTHESIS
    // An accepted word starts the heading reduction next cycle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_HEAD))
        else $error("accepted word did not start the sequence");

    // A dead-band result carries zero drive
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_dead_band) |-> (o_drive == 16'sd0))
        else $error("dead-band result with nonzero drive");

    // The wrapped error stays within a half turn
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_wrapped_error <= 16'sd18000) &&
                         (o_wrapped_error >= -16'sd18000)))
        else $error("wrapped error out of range");

    // A result implies the reference has been fixed
    a_ref_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_ref_valid)
        else $error("result without a reference heading");
`endif

endmodule

// ===== tb/tb_heading_pd_controller_unit.sv =====
// Self-checking testbench of the heading PD controller: directed table, then random phases.
module tb_heading_pd_controller_unit
    import hpdc_pkg::*;
();

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 60;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 60;
    localparam int HALF_TURN       = 18000;
    localparam int FULL_TURN       = 36000;
    localparam int MS_PER_S        = 1000;

    // Unused indexes of the configuration port
    localparam logic [2:0] REG_SPARE_LO   = 3'd4;
    localparam logic [2:0] REG_SPARE_MID  = 3'd5;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [15:0] err;
        logic               dead;
    } t_steer;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [15:0]        hdg;
        logic signed [15:0] tgt;
        logic [15:0]        ms;
        logic               rz;
        logic [2:0]         idx;
        logic [15:0]        val;
        bit                 typed;
        t_steer             want;
    } t_plan_row;

    // Clock, reset and block inputs, all known from time zero
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [15:0]        in_heading = '0;
    logic signed [15:0] in_target  = '0;
    logic [15:0]        in_ms      = '0;
    logic               in_rezero  = 1'b0;
    logic               out_stall  = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic [2:0]         cfg_index  = '0;
    logic [15:0]        cfg_data   = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [15:0] o_drive;
    logic signed [15:0] o_wrapped_error;
    logic               o_in_dead_band;
    logic               o_cfg_ready;

    // Predictor copy of registers and controller state
    logic [15:0] kp_q      = '0;
    logic [15:0] kd_q      = '0;
    logic [14:0] cap_q     = '0;
    logic [14:0] band_q    = '0;
    int          ref_hdg   = 0;
    bit          ref_set   = 1'b0;
    int          last_err  = 0;

    t_steer      pending_steer[$];
    t_plan_row   plan[$];
    int          fault_count   = 0;
    int          results_seen  = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          course        = 0;
    bit          hold_req      = 1'b0;

    heading_pd_controller_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_heading_now   (in_heading),
        .i_target_offset (in_target),
        .i_elapsed_ms    (in_ms),
        .i_rezero        (in_rezero),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_drive         (o_drive),
        .o_wrapped_error (o_wrapped_error),
        .o_in_dead_band  (o_in_dead_band),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_steer.size());
            $display("[heading_pd_controller_unit] ERROR");
            $finish;
        end
    end

    task automatic report_fault(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        fault_count++;
    endtask

    // Fold an angle difference back into +-half turn; the bounds stay as they are
    function automatic int fold_angle(input int v);
        if (v > HALF_TURN) v -= FULL_TURN;
        if (v < -HALF_TURN) v += FULL_TURN;
        return v;
    endfunction

    // Advance the controller state by one word and return its result word
    function automatic t_steer compute_steer(input logic [15:0] hdg_in,
                                             input logic signed [15:0] tgt,
                                             input logic [15:0] ms,
                                             input logic rz);
        int     hdg;
        int     err;
        int     mag;
        longint span;
        longint rate;
        longint gain_p;
        longint gain_d;
        longint lim;
        longint cmd;
        t_steer r;
        hdg = int'(hdg_in);
        if (hdg >= FULL_TURN) hdg -= FULL_TURN;
        if (!ref_set || rz) begin
            ref_hdg  = hdg;
            ref_set  = 1'b1;
            last_err = 0;
        end
        err    = fold_angle(fold_angle(hdg - ref_hdg) - int'(tgt));
        mag    = (err < 0) ? -err : err;
        r.dead = (mag <= int'(band_q));
        cmd    = 0;
        if (!r.dead) begin
            span   = longint'(ms);
            gain_p = longint'(kp_q);
            gain_d = longint'(kd_q);
            lim    = longint'(cap_q);
            rate   = 0;
            if (span != 0) rate = (longint'(err - last_err) * MS_PER_S) / span;
            cmd = -((longint'(err) * gain_p) / 256) - ((rate * gain_d) / 256);
            if (cmd > lim) cmd = lim;
            if (cmd < -lim) cmd = -lim;
        end
        last_err = err;
        r.drive  = cmd[15:0];
        r.err    = err[15:0];
        return r;
    endfunction

    // Write one register and mirror it once the port takes it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            REG_PROP_GAIN:  kp_q   = val;
            REG_DERIV_GAIN: kd_q   = val;
            REG_MAX_DRIVE:  cap_q  = val[14:0];
            REG_DEAD_BAND:  band_q = val[14:0];
            default: ;
        endcase
    endtask

    // Offer one word and queue its expected result on acceptance
    task automatic send_word(input logic [15:0] hdg, input logic signed [15:0] tgt,
                             input logic [15:0] ms, input logic rz,
                             input bit typed, input t_steer want);
        t_steer calc;
        in_valid   <= 1'b1;
        in_heading <= hdg;
        in_target  <= tgt;
        in_ms      <= ms;
        in_rezero  <= rz;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        calc = compute_steer(hdg, tgt, ms, rz);
        pending_steer.push_back(typed ? want : calc);
    endtask

    // Insert a random gap at the end of each burst unless steady
    task automatic pace_sender(input bit steady);
        int gap;
        if (steady) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 20);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge clk);
    endtask

    function automatic t_plan_row word_row(input logic [15:0] h, input logic signed [15:0] t,
                                           input logic [15:0] ms, input logic rz);
        t_plan_row r;
        r       = '{kind: ROW_WORD, default: '0};
        r.kind  = ROW_WORD;
        r.hdg   = h;
        r.tgt   = t;
        r.ms    = ms;
        r.rz    = rz;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic t_plan_row known_row(input logic [15:0] h, input logic signed [15:0] t,
                                            input logic [15:0] ms, input logic rz,
                                            input int d, input int e, input logic q);
        t_plan_row r;
        r       = word_row(h, t, ms, rz);
        r.typed = 1'b1;
        r.want  = '{drive: d[15:0], err: e[15:0], dead: q};
        return r;
    endfunction

    function automatic t_plan_row reg_row(input logic [2:0] idx, input logic [15:0] val);
        t_plan_row r;
        r      = '{kind: ROW_REG, default: '0};
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // Pick a fresh setting for every register, extremes included
    task automatic retune();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 16'hFFFF;
            5:       v = 16'($urandom);
            default: v = 16'($urandom_range(0, 1024));
        endcase
        write_reg(REG_PROP_GAIN, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 16'hFFFF;
            5:       v = 16'($urandom);
            default: v = 16'($urandom_range(0, 48));
        endcase
        write_reg(REG_DERIV_GAIN, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 16'h7FFF;
            2:       v = 16'hFFFF;
            5:       v = 16'($urandom);
            default: v = {$urandom_range(0, 1) == 0, 15'($urandom_range(1, 3000))};
        endcase
        write_reg(REG_MAX_DRIVE, v);
        case ($urandom_range(0, 6))
            0:       v = '0;
            1:       v = 16'(HALF_TURN);
            2:       v = 16'hFFFF;
            3:       v = 16'($urandom);
            default: v = {$urandom_range(0, 1) == 0, 15'($urandom_range(0, 400))};
        endcase
        write_reg(REG_DEAD_BAND, v);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly small steps around the last heading, with wild headings mixed in
    task automatic offer_random_word(input bit steady);
        int          pick;
        int          d;
        int          h;
        int          t;
        logic [15:0] ms;
        logic        rz;
        pick = $urandom_range(0, 19);
        d    = $urandom_range(0, 4000);
        if (pick < 14) h = (course + d + FULL_TURN - 2000) % FULL_TURN;
        else if (pick < 17) h = $urandom_range(0, FULL_TURN - 1);
        else h = $urandom_range(0, 65535);
        course = h % FULL_TURN;
        pick = $urandom_range(0, 9);
        d    = $urandom_range(0, 65535);
        if (pick < 5) t = (d % 6001) - 3000;
        else if (pick < 8) t = (d % (FULL_TURN + 1)) - HALF_TURN;
        else t = d - 32768;
        pick = $urandom_range(0, 19);
        if (pick < 3) ms = '0;
        else if (pick < 13) ms = 16'($urandom_range(1, 100));
        else if (pick < 18) ms = 16'($urandom_range(101, 5000));
        else ms = 16'($urandom_range(0, 65535));
        rz = ($urandom_range(0, 19) == 0);
        send_word(h[15:0], t[15:0], ms, rz, 1'b0, '0);
        pace_sender(steady);
    endtask

    // Receiver: random stall modes in stretches, and a long hold-off on request
    initial begin
        int stretch;
        int mode;
        int k;
        forever begin
            if (hold_req) begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(8, 120);
                for (k = 0; k < stretch && !hold_req; k++) begin
                    @(posedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= 1'($urandom_range(0, 1));
                    endcase
                end
            end
        end
    end

    // Compare each drained word with the oldest expectation
    always @(posedge clk) begin
        t_steer want;
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (pending_steer.size() == 0) begin
                report_fault($sformatf("unexpected word drive=%0d err=%0d dead=%0b",
                                       o_drive, o_wrapped_error, o_in_dead_band));
            end else begin
                want = pending_steer.pop_front();
                if (o_drive !== want.drive)
                    report_fault($sformatf("drive got %0d, expected %0d",
                                           o_drive, want.drive));
                if (o_wrapped_error !== want.err)
                    report_fault($sformatf("wrapped_error got %0d, expected %0d",
                                           o_wrapped_error, want.err));
                if (o_in_dead_band !== want.dead)
                    report_fault($sformatf("in_dead_band got %0b, expected %0b",
                                           o_in_dead_band, want.dead));
            end
        end
    end

    initial begin
        int p;
        int n;

        // Registers at reset: everything zero, first word sets the reference
        plan.push_back(known_row(16'd12345, 16'sd0, 16'd10, 1'b0, 0, 0, 1'b1));
        plan.push_back(known_row(16'd12345, 16'sd100, 16'd10, 1'b0, 0, -100, 1'b0));
        // Unity proportional gain, full drive range
        plan.push_back(reg_row(REG_PROP_GAIN, 16'd256));
        plan.push_back(reg_row(REG_MAX_DRIVE, 16'h7FFF));
        plan.push_back(known_row(16'd0, 16'sd0, 16'd0, 1'b1, 0, 0, 1'b1));
        plan.push_back(known_row(16'd18000, 16'sd0, 16'd0, 1'b0, -18000, 18000, 1'b0));
        plan.push_back(word_row(16'd18001, 16'sd0, 16'd0, 1'b0));
        plan.push_back(word_row(16'd35999, 16'sd0, 16'd0, 1'b0));
        // Headings at or past a full turn
        plan.push_back(known_row(16'd36000, 16'sd0, 16'd0, 1'b0, 0, 0, 1'b1));
        plan.push_back(word_row(16'hFFFF, 16'sd0, 16'd0, 1'b0));
        // Target extremes, wrapped with a single fold
        plan.push_back(known_row(16'd0, -16'sd18000, 16'd0, 1'b0, -18000, 18000, 1'b0));
        plan.push_back(known_row(16'd0, 16'sh7FFF, 16'd0, 1'b0, -3233, 3233, 1'b0));
        plan.push_back(known_row(16'd0, 16'sh8000, 16'd0, 1'b0, 3232, -3232, 1'b0));
        plan.push_back(known_row(16'd18000, 16'sd18000, 16'd0, 1'b0, 0, 0, 1'b1));
        // Full gains, small clamp, dead band edge
        plan.push_back(reg_row(REG_PROP_GAIN, 16'hFFFF));
        plan.push_back(reg_row(REG_DERIV_GAIN, 16'hFFFF));
        plan.push_back(reg_row(REG_MAX_DRIVE, 16'd1000));
        plan.push_back(reg_row(REG_DEAD_BAND, 16'd100));
        plan.push_back(known_row(16'd100, 16'sd0, 16'd1, 1'b1, 0, 0, 1'b1));
        plan.push_back(known_row(16'd300, 16'sd0, 16'd1, 1'b0, -1000, 200, 1'b0));
        plan.push_back(known_row(16'd50, 16'sd0, 16'hFFFF, 1'b0, 0, -50, 1'b1));
        plan.push_back(known_row(16'd200, 16'sd0, 16'd0, 1'b0, 0, 100, 1'b1));
        plan.push_back(known_row(16'd201, 16'sd0, 16'd0, 1'b0, -1000, 101, 1'b0));
        // Dead band beyond a half turn silences everything
        plan.push_back(reg_row(REG_DEAD_BAND, 16'h7FFF));
        plan.push_back(known_row(16'd20000, -16'sd5000, 16'd7, 1'b0, 0, -11100, 1'b1));
        // Zero clamp; writes to unused indexes must not land anywhere
        plan.push_back(reg_row(REG_DEAD_BAND, 16'd0));
        plan.push_back(reg_row(REG_MAX_DRIVE, 16'd0));
        plan.push_back(reg_row(REG_SPARE_MID, 16'hFFFF));
        plan.push_back(reg_row(REG_SPARE_HI, 16'h5A5A));
        plan.push_back(known_row(16'd9000, 16'sd0, 16'd3, 1'b0, 0, 8900, 1'b0));
        // Upper data bits of the 15-bit registers are dropped
        plan.push_back(reg_row(REG_MAX_DRIVE, 16'hFFFF));
        plan.push_back(reg_row(REG_DEAD_BAND, 16'h8000));
        plan.push_back(reg_row(REG_PROP_GAIN, 16'd1));
        plan.push_back(reg_row(REG_DERIV_GAIN, 16'd300));
        plan.push_back(word_row(16'd35999, -16'sd18000, 16'hFFFF, 1'b1));
        plan.push_back(word_row(16'd100, 16'sd0, 16'd1, 1'b0));
        plan.push_back(word_row(16'd17000, -16'sd18000, 16'd2, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle_block();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                if (cfg_valid) cfg_valid <= 1'b0;
                send_word(plan[i].hdg, plan[i].tgt, plan[i].ms, plan[i].rz,
                          plan[i].typed, plan[i].want);
                pace_sender(1'b0);
            end
        end

        // Random phases, each under a new register setting
        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle_block();
            retune();
            if (p == 1) hold_req = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                if (p == 3 && n == WORDS_PER_PHASE / 2) settle_block();
                offer_random_word(p == 1);
            end
        end

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0) begin
            $display("[heading_pd_controller_unit] OK");
        end else begin
            $display("[heading_pd_controller_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== heading_pd_controller_unit.f =====
hdl/hpdc_pkg.sv
hdl/hpdc_alu.sv
hdl/heading_pd_controller_unit.sv
tb/tb_heading_pd_controller_unit.sv
